// ===== rtl/assert_macros.svh =====
// assertion helpers for the median filter checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/smf_pkg.sv =====
package smf_pkg;
   localparam int CNT_BITS = 16;
   typedef logic [CNT_BITS-1:0] cnt_type;

   // one command from front to back
   typedef struct packed {
      cnt_type pos;    // position to filter
      cnt_type n;      // sequence length when final
      logic    final_w; // edge mirroring at the end applies
      logic    last;   // last output of the sequence
   } job_type;
endpackage

// ===== rtl/smf_front.sv =====
module smf_front #(
   parameter int MAX_WINDOW  = 32,
   parameter int SAMPLE_BITS = 16,
   parameter int WB          = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [SAMPLE_BITS-1:0] in_sample,
   input  logic                          in_last,
   output logic                          in_ready,
   input  logic                          hold,
   input  logic [WB-1:0]                 width,
   output logic                          wr_en,
   output logic [smf_pkg::CNT_BITS-1:0]  wr_pos,
   output logic signed [SAMPLE_BITS-1:0] wr_data,
   output logic                          job_valid,
   output smf_pkg::job_type              job,
   input  logic                          job_ready
);
   import smf_pkg::*;

   typedef enum logic [0:0] {ST_TAKE, ST_EMIT} state_type;

   state_type state_ff, state_in;
   cnt_type   seen_ff, seen_in, emit_ff, emit_in;
   logic      fin_ff, fin_in;

   logic [WB-1:0] ahead;
   cnt_type pending, n_eff;
   logic    more;

   assign ahead   = width - WB'(1) - (width >> 1);
   assign pending = seen_ff - emit_ff;
   assign more    = fin_ff ? (pending != '0) : (pending > cnt_type'(ahead));
   // a count wrapped to zero stands for the full range
   assign n_eff   = seen_ff;

   // queued jobs must read the sample stores before a new sample lands
   assign in_ready  = (state_ff == ST_TAKE) && !hold;
   assign wr_en     = in_valid && in_ready;
   assign wr_pos    = seen_ff;
   assign wr_data   = in_sample;
   assign job_valid = (state_ff == ST_EMIT) && more;
   assign job.pos   = emit_ff;
   assign job.n     = n_eff;
   assign job.final_w = fin_ff;
   assign job.last  = fin_ff && ((emit_ff + cnt_type'(1)) == seen_ff);

   always_comb begin
      state_in = state_ff;
      seen_in  = seen_ff;
      emit_in  = emit_ff;
      fin_in   = fin_ff;
      unique case (state_ff)
         ST_TAKE: begin
            if (wr_en) begin
               seen_in  = seen_ff + cnt_type'(1);
               fin_in   = in_last;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!more) begin
               state_in = ST_TAKE;
               if (fin_ff) begin
                  seen_in = '0;
                  emit_in = '0;
                  fin_in  = 1'b0;
               end
            end else if (job_ready) begin
               emit_in = emit_ff + cnt_type'(1);
            end
         end
         default: state_in = ST_TAKE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_TAKE;
         seen_ff  <= '0;
         emit_ff  <= '0;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         seen_ff  <= seen_in;
         emit_ff  <= emit_in;
         fin_ff   <= fin_in;
      end
   end
endmodule

// ===== rtl/smf_queue.sv =====
module smf_queue #(
   parameter int DEPTH_BITS = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  smf_pkg::job_type push_data,
   output logic             ready,
   output logic             valid,
   output smf_pkg::job_type pop_data,
   input  logic             pop
);
   import smf_pkg::*;

   localparam int DEPTH = 1 << DEPTH_BITS;

   job_type mem_ff [DEPTH];
   logic [DEPTH_BITS-1:0] wp_ff, rp_ff;
   logic [DEPTH_BITS:0]   cnt_ff;

   assign ready    = (cnt_ff != (DEPTH_BITS+1)'(DEPTH));
   assign valid    = (cnt_ff != '0);
   assign pop_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push && ready) mem_ff[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push && ready) wp_ff <= wp_ff + 1'b1;
         if (pop && valid) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (DEPTH_BITS+1)'(push && ready) - (DEPTH_BITS+1)'(pop && valid);
      end
   end
endmodule

// ===== rtl/smf_back.sv =====
module smf_back #(
   parameter int MAX_WINDOW  = 32,
   parameter int SAMPLE_BITS = 16,
   parameter int WB          = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [WB-1:0]                 width,
   input  logic                          wr_en,
   input  logic [smf_pkg::CNT_BITS-1:0]  wr_pos,
   input  logic signed [SAMPLE_BITS-1:0] wr_data,
   input  logic                          job_valid,
   input  smf_pkg::job_type              job,
   output logic                          job_pop,
   output logic                          rd_busy,
   output logic                          out_valid,
   output logic signed [SAMPLE_BITS-1:0] out_data,
   output logic                          out_last,
   input  logic                          out_pop
);
   import smf_pkg::*;

   localparam int HEAD = MAX_WINDOW / 2;
   localparam int AB   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int HB   = (HEAD > 1) ? $clog2(HEAD) : 1;
   localparam int KB   = CNT_BITS + 3;

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_RANK, ST_DONE} state_type;

   logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] head_mem [(HEAD > 0) ? HEAD : 1];
   // window gathered locally so ranking compares in registers
   logic signed [SAMPLE_BITS-1:0] win_ff [MAX_WINDOW];

   state_type state_ff;
   job_type   job_ff;
   logic [WB-1:0] j_ff, c_ff, w_ff;
   logic [WB-1:0] lt_ff, le_ff;
   logic signed [SAMPLE_BITS-1:0] res_ff, med_ff;
   logic res_last_ff, med_last_ff, full_ff;
   logic load_out;

   // mirrored position for window slot j
   logic signed [KB-1:0] k0, k1, k2, k3, kf, nn;
   logic [WB-1:0] half;
   logic [AB-1:0] jidx, cidx;
   logic signed [SAMPLE_BITS-1:0] rd;

   assign half = w_ff >> 1;
   assign nn   = (job_ff.n == '0) ? KB'(1 << CNT_BITS) : KB'(job_ff.n);
   assign k0   = KB'(job_ff.pos) + KB'(j_ff) - KB'(half);
   assign k1   = (k0 < 0) ? (-k0 - KB'(1)) : k0;
   assign k2   = (job_ff.final_w && k1 >= nn) ? (nn + nn - k1 - KB'(1)) : k1;
   assign k3   = (k2 < 0) ? KB'(0) : k2;
   assign kf   = (job_ff.final_w && k3 > nn - KB'(1)) ? nn - KB'(1) : k3;
   assign jidx = j_ff[AB-1:0];
   assign cidx = c_ff[AB-1:0];

   always_comb begin
      if (HEAD > 0 && kf < KB'(HEAD)) rd = head_mem[kf[HB-1:0]];
      else rd = hist_mem[kf[AB-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_pos[AB-1:0]] <= wr_data;
         if (HEAD > 0 && wr_pos < CNT_BITS'(HEAD)) head_mem[wr_pos[HB-1:0]] <= wr_data;
      end
   end

   assign job_pop   = (state_ff == ST_IDLE) && job_valid;
   assign rd_busy   = (state_ff == ST_READ);
   assign load_out  = (state_ff == ST_DONE) && (!full_ff || out_pop);
   assign out_valid = full_ff;
   assign out_data  = res_ff;
   assign out_last  = res_last_ff;

   // rank search: the candidate whose count of smaller elements is at most
   // half and count of smaller-or-equal exceeds half is the median
   logic signed [SAMPLE_BITS-1:0] cand;
   assign cand = win_ff[cidx];

   always_ff @(posedge clock) begin
      if (load_out) begin
         res_ff      <= med_ff;
         res_last_ff <= med_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         full_ff  <= 1'b0;
      end else begin
         if (load_out) full_ff <= 1'b1;
         else if (out_pop && full_ff) full_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  job_ff <= job;
                  w_ff   <= (width == '0) ? WB'(1)
                            : (width > WB'(MAX_WINDOW)) ? WB'(MAX_WINDOW) : width;
                  j_ff   <= '0;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               win_ff[jidx] <= rd;
               if (j_ff == w_ff - WB'(1)) begin
                  c_ff  <= '0;
                  j_ff  <= '0;
                  lt_ff <= '0;
                  le_ff <= '0;
                  state_ff <= ST_RANK;
               end else begin
                  j_ff <= j_ff + WB'(1);
               end
            end
            ST_RANK: begin
               if (j_ff == w_ff) begin
                  if (lt_ff <= half && le_ff > half) begin
                     med_ff      <= cand;
                     med_last_ff <= job_ff.last;
                     state_ff    <= ST_DONE;
                  end else begin
                     c_ff  <= c_ff + WB'(1);
                     j_ff  <= '0;
                     lt_ff <= '0;
                     le_ff <= '0;
                  end
               end else begin
                  if (win_ff[jidx] < cand) lt_ff <= lt_ff + WB'(1);
                  if (win_ff[jidx] <= cand) le_ff <= le_ff + WB'(1);
                  j_ff <= j_ff + WB'(1);
               end
            end
            ST_DONE: begin
               if (load_out) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// ===== rtl/sliding_median_filter_mirror_edges.sv =====
// one-dimensional median filter with mirrored edges
// req_ channel: push a signed sample with req_last on the final sample of a
// sequence; the item is taken when req_push is high and req_full is low.
// rsp_ channel: rsp_filtered and rsp_out_last are valid while rsp_empty is
// low; rsp_pop takes them.
// csr_wr_en/csr_wr_data set the window width (reset 19; 0 acts as 1, values
// above MAX_WINDOW act as MAX_WINDOW). write only while idle.
// a sample yields its output once width-1-width/2 later samples are in; the
// last sample flushes every remaining output.
// each output gathers w window samples and ranks them by comparing one window
// sample at a time against the current candidate.
// the front takes the next sample once all outputs of the last are queued
// and the back has gathered the windows of every queued job.
// reset clears counters and queues; sample stores hold garbage until written.
// a stalled receiver fills the output register and holds the back, so jobs
// wait in the job queue and the front stops taking samples.
module sliding_median_filter_mirror_edges #(
   parameter int MAX_WINDOW  = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_last,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [SAMPLE_BITS-1:0] rsp_filtered,
   output logic                          rsp_out_last,
   input  logic                          csr_wr_en,
   input  logic [5:0]                    csr_wr_data
);
   import smf_pkg::*;

   localparam int WB = $clog2(MAX_WINDOW + 1) + 1;

   logic [5:0] width_ff;
   logic [WB-1:0] width;
   logic in_ready, wr_en, jv, jr, qv, qpop, ov, rd_busy;
   cnt_type wr_pos;
   logic signed [SAMPLE_BITS-1:0] wr_data;
   job_type job_f, job_q;

   always_ff @(posedge clock) begin
      if (reset) width_ff <= 6'd19;
      else if (csr_wr_en) width_ff <= csr_wr_data;
   end
   assign width = (width_ff == '0) ? WB'(1)
                : ((WB'(width_ff) > WB'(MAX_WINDOW)) ? WB'(MAX_WINDOW) : WB'(width_ff));

   smf_front #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS), .WB(WB)) u_front (
      .clock, .reset, .in_valid(req_push), .in_sample(req_sample), .in_last(req_last),
      .in_ready, .hold(qv || rd_busy), .width, .wr_en, .wr_pos, .wr_data,
      .job_valid(jv), .job(job_f), .job_ready(jr)
   );

   smf_queue #(.DEPTH_BITS(1)) u_queue (
      .clock, .reset, .push(jv), .push_data(job_f), .ready(jr),
      .valid(qv), .pop_data(job_q), .pop(qpop)
   );

   smf_back #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS), .WB(WB)) u_back (
      .clock, .reset, .width, .wr_en, .wr_pos, .wr_data,
      .job_valid(qv), .job(job_q), .job_pop(qpop), .rd_busy,
      .out_valid(ov), .out_data(rsp_filtered), .out_last(rsp_out_last), .out_pop(rsp_pop)
   );

   assign req_full  = !in_ready;
   assign rsp_empty = !ov;
endmodule

// ===== rtl/smf_checker.sv =====
`include "assert_macros.svh"

module smf_checker (
   input logic clock,
   input logic reset,
   input logic req_push,
   input logic req_full,
   input logic rsp_empty,
   input logic rsp_pop,
   input logic rsp_out_last
);
   // an item stays present, with its last flag unchanged, until popped
   `CHK_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty, "rsp item dropped")
   `CHK_NEXT(a_last_hold, clock, reset, !rsp_empty && !rsp_pop, $stable(rsp_out_last), "last flag changed")
   // an accepted sample is still being worked on next cycle
   `CHK_NEXT(a_busy, clock, reset, req_push && !req_full, req_full, "front took two items in a row")
   `CHK_ALWAYS(a_rst_empty, clock, reset, !$past(reset) || rsp_empty, "output after reset")
endmodule

bind sliding_median_filter_mirror_edges smf_checker u_smf_checker (
   .clock, .reset, .req_push, .req_full, .rsp_empty, .rsp_pop, .rsp_out_last
);

// ===== sim/tb_top.sv =====
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W = 32;
   localparam int HEAD_N = MAX_W / 2;
   localparam int MAX_OUT = MAX_W / 2 + 1;

   typedef struct {
      logic signed [15:0] filtered;
      logic               out_last;
   } filt_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   logic signed [15:0]  req_sample = '0;
   logic                req_last = 1'b0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   logic signed [15:0]  rsp_filtered;
   logic                rsp_out_last;
   logic                csr_wr_en = 1'b0;
   logic [5:0]          csr_wr_data = '0;

   sliding_median_filter_mirror_edges uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_sample(req_sample), .req_last(req_last),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_filtered(rsp_filtered), .rsp_out_last(rsp_out_last),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // filter state mirror
   logic signed [15:0] ring_q [MAX_W];
   logic signed [15:0] head_q [HEAD_N];
   logic [15:0]        seen_cnt;
   logic [15:0]        emit_cnt;
   logic [5:0]         width_reg;
   filt_result_type    median_expect_q [$];
   int                 mismatches = 0;
   bit                 idle_on = 1'b1;
   int                 stall_left = 0;

   function automatic logic signed [15:0] window_median(int i, int n, bit fin, int w);
      logic signed [15:0] win [MAX_W];
      logic signed [15:0] v;
      int half, k, a, b;
      half = w / 2;
      for (int j = 0; j < w; j++) begin
         k = i + j - half;
         if (k < 0) k = -k - 1;
         if (fin && k >= n) k = 2 * n - k - 1;
         if (k < 0) k = 0;
         if (fin && k > n - 1) k = n - 1;
         win[j] = (k < HEAD_N) ? head_q[k] : ring_q[k % MAX_W];
      end
      for (a = 1; a < w; a++) begin
         v = win[a];
         b = a - 1;
         while (b >= 0 && win[b] > v) begin
            win[b + 1] = win[b];
            b--;
         end
         win[b + 1] = v;
      end
      return win[half];
   endfunction

   function automatic void predict_sample(logic signed [15:0] s, bit lst);
      int w, ahead, n, cnt;
      logic [15:0] pend;
      filt_result_type r;
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
      ahead = w - 1 - w / 2;
      ring_q[seen_cnt % MAX_W] = s;
      if (seen_cnt < HEAD_N) head_q[seen_cnt] = s;
      seen_cnt = seen_cnt + 16'd1;
      n = (seen_cnt == 0) ? 65536 : seen_cnt;
      cnt = 0;
      while (cnt < MAX_OUT) begin
         pend = seen_cnt - emit_cnt;
         if (lst ? (pend == 0) : (pend <= ahead)) break;
         r.filtered = window_median(emit_cnt, n, lst, w);
         emit_cnt = emit_cnt + 16'd1;
         r.out_last = lst && (emit_cnt == seen_cnt);
         median_expect_q.push_back(r);
         cnt++;
      end
      if (lst) begin
         seen_cnt = '0;
         emit_cnt = '0;
      end
   endfunction

   // receiver with stall bursts
   always @(negedge clock) begin
      if (!idle_on) begin
         rsp_pop <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_pop <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      filt_result_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (median_expect_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: filtered=%0d out_last=%0b", rsp_filtered,
                        rsp_out_last);
         end else begin
            e = median_expect_q.pop_front();
            if (e.filtered !== rsp_filtered || e.out_last !== rsp_out_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d/%0b got %0d/%0b", e.filtered,
                           e.out_last, rsp_filtered, rsp_out_last);
            end
         end
      end
   end

   // leaves req_push high; the next call or wait_drained decides what follows
   task automatic send_item(logic signed [15:0] s, bit lst);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_push <= 1'b1;
      req_sample <= s;
      req_last <= lst;
      do @(posedge clock); while (req_full);
      predict_sample(s, lst);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (median_expect_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_width(logic [5:0] v);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      width_reg = v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_sequence(int len);
      for (int i = 0; i < len; i++)
         send_item(16'($urandom), i == len - 1);
   endtask

   task automatic test_edges();
      // reset width 19, sequence shorter than half a window
      send_item(16'sh7fff, 0);
      send_item(-16'sh8000, 0);
      send_item(16'sh0000, 0);
      send_item(-16'sh0001, 0);
      send_item(16'sh0001, 1);
      set_width(6'd0);              // acts as one
      send_item(-16'sh8000, 0);
      send_item(16'sh7fff, 1);
      set_width(6'd63);             // clips to the maximum
      send_item(16'sh1234, 0);
      send_item(-16'sh4321, 0);
      send_item(16'sh7fff, 1);
      set_width(6'd2);              // even width: upper median
      send_item(16'sh0055, 1);      // single sample
      send_item(16'sh0010, 0);
      send_item(-16'sh0010, 0);
      send_item(16'sh0020, 0);
      send_item(16'sh0005, 1);
      set_width(6'd32);
      send_sequence(6);
   endtask

   task automatic test_pause();
      set_width(6'd5);
      send_sequence(0);
      for (int i = 0; i < 10; i++) send_item(16'($urandom), 0);
      wait_drained();
      for (int i = 0; i < 6; i++) send_item(16'($urandom), i == 5);
   endtask

   task automatic test_random(int items);
      int sent, len;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 3))
               0: set_width(6'd1);
               1: set_width(6'd32);
               2: set_width(6'($urandom_range(33, 63)));
               default: set_width(6'($urandom_range(0, 31)));
            endcase
         end
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(33, 45) : $urandom_range(1, 20);
         send_sequence(len);
         sent += len;
      end
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      seen_cnt = '0;
      emit_cnt = '0;
      width_reg = 6'd19;
      test_edges();
      test_pause();
      test_random(230);
      idle_on = 1'b0;
      test_random(50);
      wait_drained();
      repeat (50) @(negedge clock);
      if (mismatches == 0 && median_expect_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #60ms;
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
